@@ sv/drz_pkg.sv @@
// Shared constants, types and helper functions for the depth reprojection z-buffer.
package drz_pkg;

    localparam int IMG_WIDTH_DEF  = 640;
    localparam int IMG_HEIGHT_DEF = 480;

    localparam int REQ_W     = 2;
    localparam int ROW_W     = 9;
    localparam int COL_W     = 10;
    localparam int DEPTH_W   = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 33;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_PROJECT = 2'd0,
        REQ_READ    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NOP     = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_FOCAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FOCAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION  = 3'd5;

    localparam logic [CFG_W-1:0] RST_CENTER      = 64'h0;
    localparam logic [CFG_W-1:0] RST_FOCAL       = 64'h0001_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_ROTATION    = 64'h4000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_TRANSLATION = 64'h0;

    // arithmetic steps of a project transaction, in issue order
    typedef enum logic [3:0] {
        STP_DX = 4'd0,
        STP_DY = 4'd1,
        STP_QX = 4'd2,
        STP_QY = 4'd3,
        STP_UC = 4'd4,
        STP_VS = 4'd5,
        STP_VC = 4'd6,
        STP_US = 4'd7,
        STP_MX = 4'd8,
        STP_MY = 4'd9,
        STP_CX = 4'd10,
        STP_CY = 4'd11,
        STP_RX = 4'd12,
        STP_RY = 4'd13
    } t_step;

    localparam logic signed [49:0] SAT_POS = 50'sh7FFF_FFFF_FFFF;

    function automatic logic signed [47:0] sat47(input logic signed [49:0] v);
        logic signed [49:0] r;
        if (v > SAT_POS) begin
            r = SAT_POS;
        end else if (v < -SAT_POS) begin
            r = -SAT_POS;
        end else begin
            r = v;
        end
        return r[47:0];
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        logic signed [47:0] n;
        n = -v;
        return v[47] ? n : v;
    endfunction

    function automatic logic [32:0] mag32(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return w[32] ? 33'(-w) : 33'(w);
    endfunction

endpackage

@@ sv/drz_req_if.sv @@
// Request channel: request type, pixel coordinates and depth sample.
interface drz_req_if;
    logic                          valid;
    logic                          ready;
    logic [drz_pkg::REQ_W-1:0]     req_type;
    logic [drz_pkg::ROW_W-1:0]     row;
    logic [drz_pkg::COL_W-1:0]     col;
    logic [drz_pkg::DEPTH_W-1:0]   depth;

    modport source (output valid, req_type, row, col, depth, input ready);
    modport sink   (input valid, req_type, row, col, depth, output ready);
endinterface

@@ sv/drz_res_if.sv @@
// Result channel: landing flag, target pixel and read-back depth.
interface drz_res_if;
    logic                          valid;
    logic                          ready;
    logic                          landed;
    logic [drz_pkg::ROW_W-1:0]     target_row;
    logic [drz_pkg::COL_W-1:0]     target_col;
    logic [drz_pkg::DEPTH_W-1:0]   read_depth;

    modport source (output valid, landed, target_row, target_col, read_depth, input ready);
    modport sink   (input valid, landed, target_row, target_col, read_depth, output ready);
endinterface

@@ sv/drz_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module drz_mul (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_start,
    input  logic [drz_pkg::MUL_A_W-1:0]                     i_a,
    input  logic [drz_pkg::MUL_B_W-1:0]                     i_b,
    output logic                                            o_done,
    output logic [drz_pkg::MUL_A_W+drz_pkg::MUL_B_W-1:0]    o_prod
);
    localparam int A_W   = drz_pkg::MUL_A_W;
    localparam int B_W   = drz_pkg::MUL_B_W;
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [P_W-1:0]   r_p;
    logic [A_W:0]     sum;

    // upper half accumulates, lower half shifts the multiplier out
    assign sum = {1'b0, r_p[P_W-1:B_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {sum, r_p[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

@@ sv/drz_div.sv @@
// Restoring divider, one quotient bit per cycle.
module drz_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [drz_pkg::DIV_N_W-1:0]  i_num,
    input  logic [drz_pkg::DIV_D_W-1:0]  i_den,
    output logic                         o_done,
    output logic [drz_pkg::DIV_N_W-1:0]  o_quo
);
    localparam int N_W   = drz_pkg::DIV_N_W;
    localparam int D_W   = drz_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [N_W-1:0]   r_dq;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    assign trial = {r_rem, r_dq[N_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_dq  <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            r_dq  <= {r_dq[N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dq;
endmodule

@@ sv/drz_zbuf.sv @@
// Nearest-depth store: single memory with a clearing sweep after reset.
module drz_zbuf #(
    parameter int DEPTH = drz_pkg::IMG_WIDTH_DEF * drz_pkg::IMG_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_addr,
    input  logic [drz_pkg::DEPTH_W-1:0]  i_wr_data,
    output logic [drz_pkg::DEPTH_W-1:0]  o_rd_data,
    output logic                         o_ready
);
    logic [drz_pkg::DEPTH_W-1:0] r_mem [DEPTH];
    logic [drz_pkg::DEPTH_W-1:0] r_rd_data;
    logic                        r_clr;
    logic [AW-1:0]               r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr;
endmodule

@@ sv/depth_reprojection_zbuffer.sv @@
// Depth-to-colour reprojection with nearest-depth z-buffer: top level and sequencer.
//
// Requests enter on i_req (valid/ready), one result per request leaves on o_res.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. One request
// is in flight at a time. A project request runs ten multiplies on a bit-serial
// multiplier and four divides on a restoring divider, then a read-modify-write of
// the store. A read passes DECODE, MEM_RD, MEM_CHK and DONE; a clear, an
// out-of-frame access or the unused request type 3 goes from DECODE to DONE.
// After reset the store is swept to zero, one entry a cycle; no request is accepted
// during the sweep. Configuration registers return to their defaults at reset.
// The result sits in an output register; when the receiver stalls the result
// holds there and a finished request waits, but the next request is still
// accepted while the previous result waits.
module depth_reprojection_zbuffer #(
    parameter int IMG_WIDTH  = drz_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = drz_pkg::IMG_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [drz_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [drz_pkg::CFG_W-1:0]       i_cfg_data,
    drz_req_if.sink                         i_req,
    drz_res_if.source                       o_res
);
    localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(IMG_WIDTH);
    localparam int RW    = $clog2(IMG_HEIGHT);
    localparam int ROW_W = drz_pkg::ROW_W;
    localparam int COL_W = drz_pkg::COL_W;
    localparam int DW    = drz_pkg::DEPTH_W;
    localparam int PW    = drz_pkg::MUL_A_W + drz_pkg::MUL_B_W;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECODE  = 7'b0000010,
        ST_LAUNCH  = 7'b0000100,
        ST_WAIT    = 7'b0001000,
        ST_MEM_RD  = 7'b0010000,
        ST_MEM_CHK = 7'b0100000,
        ST_DONE    = 7'b1000000
    } t_state;

    // configuration
    logic [63:0] r_dc, r_df, r_cc, r_cf, r_rot, r_trans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc    <= drz_pkg::RST_CENTER;
            r_df    <= drz_pkg::RST_FOCAL;
            r_cc    <= drz_pkg::RST_CENTER;
            r_cf    <= drz_pkg::RST_FOCAL;
            r_rot   <= drz_pkg::RST_ROTATION;
            r_trans <= drz_pkg::RST_TRANSLATION;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                drz_pkg::CFG_DEPTH_CENTER: r_dc    <= i_cfg_data;
                drz_pkg::CFG_DEPTH_FOCAL:  r_df    <= i_cfg_data;
                drz_pkg::CFG_COLOR_CENTER: r_cc    <= i_cfg_data;
                drz_pkg::CFG_COLOR_FOCAL:  r_cf    <= i_cfg_data;
                drz_pkg::CFG_ROTATION:     r_rot   <= i_cfg_data;
                drz_pkg::CFG_TRANSLATION:  r_trans <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control and transaction registers
    t_state         r_state, n_state;
    drz_pkg::t_step r_step;
    drz_pkg::t_req  r_req;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [DW-1:0]    r_d;
    logic [AW-1:0]    r_addr;
    logic             r_inb;
    logic             r_landed;
    logic [DW-1:0]    r_rdd;
    logic [CW-1:0]    r_tc;
    logic [RW-1:0]    r_ty;

    logic [47:0]        r_ax, r_ay;
    logic signed [47:0] r_u, r_v, r_xr, r_yr;
    logic signed [48:0] r_p0;
    logic [61:0]        r_mx, r_my;
    logic signed [63:0] r_nx, r_ny;

    logic r_ov;
    logic r_o_landed;
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_col;
    logic [DW-1:0]    r_o_rdd;

    // arithmetic units and store
    logic                           mul_start, mul_done;
    logic [drz_pkg::MUL_A_W-1:0]    mul_a;
    logic [drz_pkg::MUL_B_W-1:0]    mul_b;
    logic [PW-1:0]                  mul_p;
    logic                           div_start, div_done;
    logic [drz_pkg::DIV_N_W-1:0]    div_n;
    logic [drz_pkg::DIV_D_W-1:0]    div_d;
    logic [drz_pkg::DIV_N_W-1:0]    div_q;
    logic                           zb_rd_en, zb_wr_en, zb_ready;
    logic [DW-1:0]                  zb_wr_data, zb_rd_data;

    drz_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    drz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    drz_zbuf #(.DEPTH(DEPTH), .AW(AW)) u_zbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (zb_rd_en),
        .i_wr_en   (zb_wr_en),
        .i_addr    (r_addr),
        .i_wr_data (zb_wr_data),
        .o_rd_data (zb_rd_data),
        .o_ready   (zb_ready)
    );

    // datapath terms
    logic signed [31:0] cs, sn;
    logic signed [33:0] diffx, diffy;
    logic [31:0]        magx, magy;
    logic               is_mul;
    logic               unit_done;
    logic [46:0]        q47;
    logic signed [49:0] cam, tsel;
    logic signed [47:0] u_new;
    logic [47:0]        m30;
    logic               neg30;
    logic signed [48:0] p_new;
    logic signed [47:0] xr_new, yr_new;
    logic [61:0]        m62;
    logic signed [63:0] mext, n_new;
    logic               negm;
    logic               nsign;
    logic [63:0]        lim;
    logic               pix_fail;
    logic               accept;
    logic               better;
    logic [AW-1:0]      proj_addr;

    assign cs = $signed(r_rot[63:32]);
    assign sn = $signed(r_rot[31:0]);

    assign diffx = $signed({8'd0, r_col, 16'd0}) - $signed({2'd0, r_dc[63:32]});
    assign diffy = $signed({9'd0, r_row, 16'd0}) - $signed({2'd0, r_dc[31:0]});
    assign magx  = diffx[33] ? 32'(-diffx) : 32'(diffx);
    assign magy  = diffy[33] ? 32'(-diffy) : 32'(diffy);

    assign is_mul = !(r_step == drz_pkg::STP_QX || r_step == drz_pkg::STP_QY ||
                      r_step == drz_pkg::STP_RX || r_step == drz_pkg::STP_RY);
    assign unit_done = is_mul ? mul_done : div_done;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = '0;
        case (r_step)
            drz_pkg::STP_DX: begin mul_a = 48'(magx); mul_b = 33'(r_d); end
            drz_pkg::STP_DY: begin mul_a = 48'(magy); mul_b = 33'(r_d); end
            drz_pkg::STP_QX: begin div_n = {r_ax, 16'd0}; div_d = r_df[63:32]; end
            drz_pkg::STP_QY: begin div_n = {r_ay, 16'd0}; div_d = r_df[31:0]; end
            drz_pkg::STP_UC: begin mul_a = drz_pkg::mag48(r_u); mul_b = drz_pkg::mag32(cs); end
            drz_pkg::STP_VS: begin mul_a = drz_pkg::mag48(r_v); mul_b = drz_pkg::mag32(sn); end
            drz_pkg::STP_VC: begin mul_a = drz_pkg::mag48(r_v); mul_b = drz_pkg::mag32(cs); end
            drz_pkg::STP_US: begin mul_a = drz_pkg::mag48(r_u); mul_b = drz_pkg::mag32(sn); end
            drz_pkg::STP_MX: begin mul_a = drz_pkg::mag48(r_xr); mul_b = 33'(r_cf[63:32]); end
            drz_pkg::STP_MY: begin mul_a = drz_pkg::mag48(r_yr); mul_b = 33'(r_cf[31:0]); end
            drz_pkg::STP_CX: begin mul_a = 48'(r_cc[63:32]); mul_b = 33'(r_d); end
            drz_pkg::STP_CY: begin mul_a = 48'(r_cc[31:0]); mul_b = 33'(r_d); end
            drz_pkg::STP_RX: begin
                div_n = 64'(r_nx[63] ? -r_nx : r_nx) + (64'(r_d) << 15);
                div_d = {r_d, 16'd0};
            end
            drz_pkg::STP_RY: begin
                div_n = 64'(r_ny[63] ? -r_ny : r_ny) + (64'(r_d) << 15);
                div_d = {r_d, 16'd0};
            end
            default: ;
        endcase
    end

    // back-projection: saturate the Q32.16 quotient, then remove the translation
    assign q47  = (|div_q[63:47]) ? {47{1'b1}} : div_q[46:0];
    assign cam  = ((r_step == drz_pkg::STP_QX) ? diffx[33] : diffy[33])
                  ? -$signed({3'd0, q47}) : $signed({3'd0, q47});
    assign tsel = (r_step == drz_pkg::STP_QX) ? 50'($signed(r_trans[63:32]))
                                              : 50'($signed(r_trans[31:0]));
    assign u_new = drz_pkg::sat47(cam - tsel);

    // rotation products, truncated toward zero
    assign m30 = mul_p[77:30];
    always_comb begin
        case (r_step)
            drz_pkg::STP_UC: neg30 = r_u[47] ^ cs[31];
            drz_pkg::STP_VS: neg30 = r_v[47] ^ sn[31];
            drz_pkg::STP_VC: neg30 = r_v[47] ^ cs[31];
            drz_pkg::STP_US: neg30 = r_u[47] ^ sn[31];
            default:         neg30 = 1'b0;
        endcase
    end
    assign p_new  = neg30 ? -$signed({1'b0, m30}) : $signed({1'b0, m30});
    assign xr_new = drz_pkg::sat47(50'(r_p0) + 50'(p_new));
    assign yr_new = drz_pkg::sat47(50'(r_p0) - 50'(p_new));

    // colour projection numerator
    assign m62   = (|mul_p[PW-1:78]) ? {62{1'b1}} : mul_p[77:16];
    assign negm  = (r_step == drz_pkg::STP_CX) ? r_xr[47] : r_yr[47];
    assign mext  = $signed({2'd0, (r_step == drz_pkg::STP_CX) ? r_mx : r_my});
    assign n_new = (negm ? -mext : mext) + $signed({16'd0, mul_p[47:0]});

    // rounded pixel: a negative numerator only survives as pixel 0
    assign nsign    = (r_step == drz_pkg::STP_RX) ? r_nx[63] : r_ny[63];
    assign lim      = (r_step == drz_pkg::STP_RX) ? 64'(IMG_WIDTH) : 64'(IMG_HEIGHT);
    assign pix_fail = (nsign && div_q != '0) || (div_q >= lim);
    assign proj_addr = AW'(AW'(RW'(div_q)) * AW'(IMG_WIDTH) + AW'(r_tc));

    assign accept = i_req.valid && i_req.ready;
    assign better = (zb_rd_data == '0) || (zb_rd_data > r_d);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (r_req)
                    drz_pkg::REQ_PROJECT:
                        n_state = (r_df[63:32] == '0 || r_df[31:0] == '0) ? ST_DONE : ST_LAUNCH;
                    drz_pkg::REQ_READ:
                        n_state = r_inb ? ST_MEM_RD : ST_DONE;
                    default:
                        n_state = ST_DONE;
                endcase
            end
            ST_LAUNCH: n_state = ST_WAIT;
            ST_WAIT: begin
                if (unit_done) begin
                    if (r_step == drz_pkg::STP_RX) begin
                        n_state = pix_fail ? ST_DONE : ST_LAUNCH;
                    end else if (r_step == drz_pkg::STP_RY) begin
                        n_state = pix_fail ? ST_DONE : ST_MEM_RD;
                    end else begin
                        n_state = ST_LAUNCH;
                    end
                end
            end
            ST_MEM_RD:  n_state = ST_MEM_CHK;
            ST_MEM_CHK: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_ov || o_res.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= drz_pkg::STP_DX;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DECODE) begin
                r_step <= drz_pkg::STP_DX;
            end else if (r_state == ST_WAIT && unit_done && r_step != drz_pkg::STP_RY) begin
                r_step <= drz_pkg::t_step'(r_step + 4'd1);
            end
        end
    end

    assign mul_start  = (r_state == ST_LAUNCH) && is_mul;
    assign div_start  = (r_state == ST_LAUNCH) && !is_mul;
    assign zb_rd_en   = (r_state == ST_MEM_RD);
    assign zb_wr_en   = ((r_state == ST_DECODE) && (r_req == drz_pkg::REQ_CLEAR) && r_inb) ||
                        ((r_state == ST_MEM_CHK) && (r_req == drz_pkg::REQ_PROJECT) && better);
    assign zb_wr_data = (r_req == drz_pkg::REQ_CLEAR) ? '0 : r_d;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= drz_pkg::t_req'(i_req.req_type);
            r_row    <= i_req.row;
            r_col    <= i_req.col;
            r_d      <= (i_req.depth == '0) ? DW'(1) : i_req.depth;
            r_inb    <= (int'(i_req.row) < IMG_HEIGHT) && (int'(i_req.col) < IMG_WIDTH);
            r_addr   <= AW'(AW'(i_req.row) * AW'(IMG_WIDTH) + AW'(i_req.col));
            r_landed <= 1'b0;
            r_rdd    <= '0;
        end
        if (r_state == ST_WAIT && unit_done) begin
            case (r_step)
                drz_pkg::STP_DX: r_ax <= mul_p[47:0];
                drz_pkg::STP_DY: r_ay <= mul_p[47:0];
                drz_pkg::STP_QX: r_u  <= u_new;
                drz_pkg::STP_QY: r_v  <= u_new;
                drz_pkg::STP_UC: r_p0 <= p_new;
                drz_pkg::STP_VS: r_xr <= xr_new;
                drz_pkg::STP_VC: r_p0 <= p_new;
                drz_pkg::STP_US: r_yr <= yr_new;
                drz_pkg::STP_MX: r_mx <= m62;
                drz_pkg::STP_MY: r_my <= m62;
                drz_pkg::STP_CX: r_nx <= n_new;
                drz_pkg::STP_CY: r_ny <= n_new;
                drz_pkg::STP_RX: r_tc <= CW'(div_q);
                drz_pkg::STP_RY: begin
                    r_ty   <= RW'(div_q);
                    r_addr <= proj_addr;
                end
                default: ;
            endcase
        end
        if (r_state == ST_MEM_CHK) begin
            if (r_req == drz_pkg::REQ_READ) r_rdd <= zb_rd_data;
            if (r_req == drz_pkg::REQ_PROJECT && better) r_landed <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_DONE && (!r_ov || o_res.ready)) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_ov || o_res.ready)) begin
            r_o_landed <= r_landed;
            r_o_row    <= r_landed ? ROW_W'(r_ty) : '0;
            r_o_col    <= r_landed ? COL_W'(r_tc) : '0;
            r_o_rdd    <= r_rdd;
        end
    end

    assign i_req.ready      = (r_state == ST_IDLE) && zb_ready;
    assign o_res.valid      = r_ov;
    assign o_res.landed     = r_o_landed;
    assign o_res.target_row = r_o_row;
    assign o_res.target_col = r_o_col;
    assign o_res.read_depth = r_o_rdd;
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the depth reprojection z-buffer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import drz_pkg::*;

    localparam int W = IMG_WIDTH_DEF;
    localparam int H = IMG_HEIGHT_DEF;
    localparam longint SATMAG = 64'sh7FFF_FFFF_FFFF;
    localparam longint unsigned CAP62 = (64'd1 << 62) - 1;

    typedef struct packed {
        t_req              kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DEPTH_W-1:0] depth;
    } t_pix_req;

    typedef struct packed {
        logic               landed;
        logic [ROW_W-1:0]   trow;
        logic [COL_W-1:0]   tcol;
        logic [DEPTH_W-1:0] rdepth;
    } t_pix_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    drz_req_if req_ch();
    drz_res_if res_ch();

    depth_reprojection_zbuffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copies of the block's registers and store
    logic [CFG_W-1:0] regs [0:5];
    bit [DEPTH_W-1:0] zbuf [0:W*H-1];

    t_pix_req pending[$];
    t_pix_res results_due[$];
    logic [ROW_W+COL_W-1:0] hit_pool[$];

    int sent_n = 0;
    int got_n = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint clamp47(longint v);
        if (v > SATMAG) return SATMAG;
        if (v < -SATMAG) return -SATMAG;
        return v;
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned mul_shr(longint unsigned a, longint unsigned b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic longint mul_q30(longint u, longint c);
        longint unsigned m;
        m = mul_shr(mag(u), mag(c), 30);
        return ((u < 0) != (c < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint cam_coord(longint unsigned pix, longint unsigned ctr,
                                         longint unsigned foc, longint unsigned d);
        longint diff;
        longint unsigned a, qi, rem, q;
        diff = longint'(pix << 16) - longint'(ctr);
        a = mag(diff) * d;
        qi = a / foc;
        rem = a % foc;
        if (qi >= (64'd1 << 31)) q = SATMAG;
        else q = (qi << 16) + ((rem << 16) / foc);
        return (diff < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit to_pixel(longint p, longint unsigned foc, longint unsigned ctr,
                                    longint unsigned d, longint unsigned lim,
                                    output longint unsigned pix);
        longint unsigned m, den, r;
        longint n;
        pix = 0;
        m = mul_shr(mag(p), foc, 16);
        if (m > CAP62) m = CAP62;
        n = ((p < 0) ? -longint'(m) : longint'(m)) + longint'(ctr * d);
        den = d << 16;
        r = (mag(n) + den / 2) / den;
        if (n < 0 && r != 0) return 1'b0;
        if (r >= lim) return 1'b0;
        pix = r;
        return 1'b1;
    endfunction

    // works out the result of one request and applies its effect on the store
    function automatic t_pix_res reproject(t_pix_req rq);
        t_pix_res rs;
        longint unsigned d, dfx, dfy, tc, tr;
        longint cs, sn, cxp, cyp, u, v, xr, yr;
        int idx;
        rs = '0;
        if (rq.kind == REQ_READ || rq.kind == REQ_CLEAR) begin
            if (rq.row < H && rq.col < W) begin
                idx = int'(rq.row) * W + int'(rq.col);
                if (rq.kind == REQ_READ) rs.rdepth = zbuf[idx];
                else zbuf[idx] = '0;
            end
        end else if (rq.kind == REQ_PROJECT) begin
            d = (rq.depth == '0) ? 64'd1 : 64'(rq.depth);
            dfx = 64'(regs[CFG_DEPTH_FOCAL][63:32]);
            dfy = 64'(regs[CFG_DEPTH_FOCAL][31:0]);
            if (dfx == 0 || dfy == 0) return rs;
            cs = sx32(regs[CFG_ROTATION][63:32]);
            sn = sx32(regs[CFG_ROTATION][31:0]);
            cxp = cam_coord(64'(rq.col), 64'(regs[CFG_DEPTH_CENTER][63:32]), dfx, d);
            cyp = cam_coord(64'(rq.row), 64'(regs[CFG_DEPTH_CENTER][31:0]), dfy, d);
            u = clamp47(cxp - sx32(regs[CFG_TRANSLATION][63:32]));
            v = clamp47(cyp - sx32(regs[CFG_TRANSLATION][31:0]));
            xr = clamp47(mul_q30(u, cs) + mul_q30(v, sn));
            yr = clamp47(mul_q30(v, cs) - mul_q30(u, sn));
            if (to_pixel(xr, 64'(regs[CFG_COLOR_FOCAL][63:32]),
                         64'(regs[CFG_COLOR_CENTER][63:32]), d, 64'(W), tc) &&
                to_pixel(yr, 64'(regs[CFG_COLOR_FOCAL][31:0]),
                         64'(regs[CFG_COLOR_CENTER][31:0]), d, 64'(H), tr)) begin
                idx = int'(tr) * W + int'(tc);
                if (zbuf[idx] == 0 || zbuf[idx] > d) begin
                    zbuf[idx] = d[15:0];
                    rs.landed = 1'b1;
                    rs.trow = tr[ROW_W-1:0];
                    rs.tcol = tc[COL_W-1:0];
                    if (hit_pool.size() >= 64) void'(hit_pool.pop_front());
                    hit_pool.push_back({rs.trow, rs.tcol});
                end
            end
        end
        return rs;
    endfunction

    function automatic bit quiet_stretch(int n);
        return n >= 400 && n < 600;
    endfunction

    // request driver
    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.row = '0;
        req_ch.col = '0;
        req_ch.depth = '0;
        res_ch.ready = 1'b0;
    end

    task automatic offer_next();
        if (pending.size() > 0 && (quiet_stretch(sent_n) || $urandom_range(99) >= 8)) begin
            req_ch.valid <= 1'b1;
            req_ch.req_type <= pending[0].kind;
            req_ch.row <= pending[0].row;
            req_ch.col <= pending[0].col;
            req_ch.depth <= pending[0].depth;
        end else begin
            req_ch.valid <= 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && req_ch.ready) begin
            results_due.push_back(reproject(pending.pop_front()));
            sent_n++;
            offer_next();
        end else if (!req_ch.valid) begin
            offer_next();
        end
    end

    // long receiver hold-off so that the block backs up onto its input
    always @(posedge i_clk) begin
        if (!hold_done && got_n == 200) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= (hold_left == 0) &&
                             (quiet_stretch(got_n) || $urandom_range(99) >= 8);
    end

    // result monitor
    always @(posedge i_clk) begin
        t_pix_res act, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            act = {res_ch.landed, res_ch.target_row, res_ch.target_col, res_ch.read_depth};
            got_n++;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", act);
            end else begin
                want = results_due.pop_front();
                if (act.landed !== want.landed || act.trow !== want.trow ||
                    act.tcol !== want.tcol || act.rdepth !== want.rdepth) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p, got %p",
                                 got_n, want, act);
                end
            end
        end
    end

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        regs[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_req(t_req k, int r, int c, int d);
        t_pix_req rq;
        rq.kind = k;
        rq.row = ROW_W'(r);
        rq.col = COL_W'(c);
        rq.depth = DEPTH_W'(d);
        pending.push_back(rq);
    endtask

    task automatic drain();
        @(negedge i_clk);
        wait (pending.size() == 0 && results_due.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] q16(int ipart);
        return {ipart[15:0], 16'($urandom)};
    endfunction

    task automatic load_setting(int mode);
        logic [31:0] c, s;
        int ang;
        case (mode)
            1, 2: begin
                ang = $urandom_range(1 << 26);
                s = $urandom_range(1) ? ang : -ang;
                c = (1 << 30) - $urandom_range(1 << 22);
                put_reg(CFG_DEPTH_CENTER, {q16(300 + $urandom_range(40)),
                                           q16(220 + $urandom_range(40))});
                put_reg(CFG_DEPTH_FOCAL, {q16(450 + $urandom_range(150)),
                                          q16(450 + $urandom_range(150))});
                put_reg(CFG_COLOR_CENTER, {q16(300 + $urandom_range(40)),
                                           q16(220 + $urandom_range(40))});
                put_reg(CFG_COLOR_FOCAL, {q16(450 + $urandom_range(150)),
                                          q16(450 + $urandom_range(150))});
                put_reg(CFG_ROTATION, {c, s});
                put_reg(CFG_TRANSLATION, {32'($urandom_range(1 << 22)) - 32'(1 << 21),
                                          32'($urandom_range(1 << 22)) - 32'(1 << 21)});
            end
            3: begin
                put_reg(CFG_DEPTH_CENTER, '1);
                put_reg(CFG_DEPTH_FOCAL, '1);
                put_reg(CFG_COLOR_CENTER, '1);
                put_reg(CFG_COLOR_FOCAL, '1);
                put_reg(CFG_ROTATION, '1);
                put_reg(CFG_TRANSLATION, '1);
            end
            4: begin
                put_reg(CFG_DEPTH_CENTER, '0);
                put_reg(CFG_DEPTH_FOCAL, '0);
                put_reg(CFG_COLOR_CENTER, '0);
                put_reg(CFG_COLOR_FOCAL, '0);
                put_reg(CFG_ROTATION, '0);
                put_reg(CFG_TRANSLATION, '0);
            end
            5: begin
                put_reg(CFG_DEPTH_CENTER, {$urandom, $urandom});
                put_reg(CFG_DEPTH_FOCAL, {$urandom, $urandom});
                put_reg(CFG_COLOR_CENTER, {$urandom, $urandom});
                put_reg(CFG_COLOR_FOCAL, {$urandom, $urandom});
                put_reg(CFG_ROTATION, {$urandom, $urandom});
                put_reg(CFG_TRANSLATION, {$urandom, $urandom});
            end
            default: begin
                put_reg(CFG_DEPTH_CENTER, RST_CENTER);
                put_reg(CFG_DEPTH_FOCAL, RST_FOCAL);
                put_reg(CFG_COLOR_CENTER, RST_CENTER);
                put_reg(CFG_COLOR_FOCAL, RST_FOCAL);
                put_reg(CFG_ROTATION, RST_ROTATION);
                put_reg(CFG_TRANSLATION, RST_TRANSLATION);
            end
        endcase
    endtask

    task automatic random_reqs(int n);
        int pick, r, c, d;
        logic [ROW_W+COL_W-1:0] spot;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            d = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(300, 5000);
            if ($urandom_range(19) == 0) d = $urandom_range(1) ? 0 : 65535;
            r = $urandom_range(H - 1);
            c = $urandom_range(W - 1);
            if (hit_pool.size() > 0 && $urandom_range(2) == 0) begin
                spot = hit_pool[$urandom_range(hit_pool.size() - 1)];
                r = int'(spot[ROW_W+COL_W-1:COL_W]);
                c = int'(spot[COL_W-1:0]);
            end
            if (pick < 70) queue_req(REQ_PROJECT, r, c, d);
            else if (pick < 82) queue_req(REQ_READ, r, c, $urandom);
            else if (pick < 92) queue_req(REQ_CLEAR, r, c, $urandom);
            else if (pick < 95) queue_req(REQ_NOP, $urandom, $urandom, $urandom);
            else queue_req(t_req'($urandom_range(3)), $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        regs[CFG_DEPTH_CENTER] = RST_CENTER;
        regs[CFG_DEPTH_FOCAL] = RST_FOCAL;
        regs[CFG_COLOR_CENTER] = RST_CENTER;
        regs[CFG_COLOR_FOCAL] = RST_FOCAL;
        regs[CFG_ROTATION] = RST_ROTATION;
        regs[CFG_TRANSLATION] = RST_TRANSLATION;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity mapping straight after reset: landing, nearer/equal and access cases
        queue_req(REQ_PROJECT, 0, 0, 0);
        queue_req(REQ_PROJECT, H - 1, W - 1, 65535);
        queue_req(REQ_PROJECT, 10, 20, 500);
        queue_req(REQ_PROJECT, 10, 20, 600);
        queue_req(REQ_PROJECT, 10, 20, 500);
        queue_req(REQ_PROJECT, 10, 20, 400);
        queue_req(REQ_READ, 10, 20, 0);
        queue_req(REQ_READ, 0, 0, 65535);
        queue_req(REQ_CLEAR, 10, 20, 0);
        queue_req(REQ_READ, 10, 20, 0);
        queue_req(REQ_READ, H, 0, 0);
        queue_req(REQ_READ, 0, W, 0);
        queue_req(REQ_READ, 511, 1023, 0);
        queue_req(REQ_CLEAR, 511, 1023, 65535);
        queue_req(REQ_NOP, 511, 1023, 65535);
        queue_req(REQ_NOP, 0, 0, 0);
        queue_req(REQ_PROJECT, 500, 700, 100);
        queue_req(REQ_PROJECT, 511, 1023, 65535);
        queue_req(REQ_READ, H - 1, W - 1, 0);
        drain();

        load_setting(4);
        queue_req(REQ_PROJECT, 5, 5, 1000);
        random_reqs(40);
        drain();

        load_setting(1);
        random_reqs(300);
        drain();
        load_setting(3);
        random_reqs(120);
        drain();
        load_setting(5);
        random_reqs(150);
        drain();
        load_setting(2);
        random_reqs(300);
        drain();
        load_setting(0);
        random_reqs(170);
        drain();

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
